FILE: sv/breakpoint_patch_table_assert.svh
// assertion macros for the breakpoint patch table
`ifndef BREAKPOINT_PATCH_TABLE_ASSERT_SVH
`define BREAKPOINT_PATCH_TABLE_ASSERT_SVH

// checked on every clock edge outside reset
`define BPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define BPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bpt_pkg.sv
// constants, types and control store of the breakpoint patch table
package bpt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [7:0] HALT_OPCODE = 8'hDB;

  // commands
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RESUME = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ALREADY   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // action codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_WRITE     = 3'd1;
  localparam logic [2:0] ACT_RELEASE   = 3'd2;
  localparam logic [2:0] ACT_READ_NEXT = 3'd3;
  localparam logic [2:0] ACT_READ_PREV = 3'd4;

  // sequencer step addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] S_LOOK     = 5'd1;
  localparam logic [STEP_W-1:0] S_DISP_SET = 5'd2;
  localparam logic [STEP_W-1:0] S_DISP_REM = 5'd3;
  localparam logic [STEP_W-1:0] S_DISP_RES = 5'd4;
  localparam logic [STEP_W-1:0] S_RES      = 5'd5;
  localparam logic [STEP_W-1:0] S_RES_W0   = 5'd6;
  localparam logic [STEP_W-1:0] S_RES_REL  = 5'd7;
  localparam logic [STEP_W-1:0] S_RES_RDN  = 5'd8;
  localparam logic [STEP_W-1:0] S_RES_RDP  = 5'd9;
  localparam logic [STEP_W-1:0] S_RES_W1   = 5'd10;
  localparam logic [STEP_W-1:0] S_RES_MISS = 5'd11;
  localparam logic [STEP_W-1:0] S_SET      = 5'd12;
  localparam logic [STEP_W-1:0] S_SET_CHK  = 5'd13;
  localparam logic [STEP_W-1:0] S_SET_ADD  = 5'd14;
  localparam logic [STEP_W-1:0] S_SET_DUP  = 5'd15;
  localparam logic [STEP_W-1:0] S_SET_FULL = 5'd16;
  localparam logic [STEP_W-1:0] S_REM      = 5'd17;
  localparam logic [STEP_W-1:0] S_REM_RDL  = 5'd18;
  localparam logic [STEP_W-1:0] S_REM_DEL  = 5'd19;
  localparam logic [STEP_W-1:0] S_REM_NF   = 5'd20;

  typedef enum logic {ASEL_ZERO, ASEL_ITEM} asel_t;
  typedef enum logic [1:0] {DSEL_ZERO, DSEL_ORIG, DSEL_HALT} dsel_t;
  typedef enum logic [1:0] {OP_NONE, OP_APPEND, OP_REMOVE} tbl_op_t;
  typedef enum logic [2:0] {
    C_ALWAYS, C_NEVER, C_IS_SET, C_IS_REM, C_NOT_RES, C_MISS, C_HIT, C_FULL
  } cond_t;

  // one control word
  typedef struct packed {
    logic              emit;
    logic [1:0]        status;
    logic [2:0]        action;
    asel_t             asel;
    dsel_t             dsel;
    logic              last;
    tbl_op_t           op;
    logic              ld_hit;
    logic              rd_last;
    logic              ld_orig;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // table write request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [15:0]      addr;
    logic [7:0]       orig;
  } tbl_wr_t;

  // control store
  function automatic ucode_t bpt_ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{emit: 1'b0, status: ST_DONE, action: ACT_NONE, asel: ASEL_ZERO,
          dsel: DSEL_ZERO, last: 1'b0, op: OP_NONE, ld_hit: 1'b0,
          rd_last: 1'b0, ld_orig: 1'b0, cond: C_NEVER, target: S_IDLE};
    unique case (step)
      S_IDLE: begin
        w.cond = C_ALWAYS;
      end
      S_LOOK: begin
        w.ld_hit = 1'b1;
      end
      S_DISP_SET: begin
        w.cond = C_IS_SET;
        w.target = S_SET;
      end
      S_DISP_REM: begin
        w.cond = C_IS_REM;
        w.target = S_REM;
      end
      S_DISP_RES: begin
        w.cond = C_NOT_RES;
        w.target = S_IDLE;
      end
      S_RES: begin
        w.ld_orig = 1'b1;
        w.cond = C_MISS;
        w.target = S_RES_MISS;
      end
      S_RES_W0: begin
        w.emit = 1'b1;
        w.action = ACT_WRITE;
        w.asel = ASEL_ITEM;
        w.dsel = DSEL_ORIG;
      end
      S_RES_REL: begin
        w.emit = 1'b1;
        w.action = ACT_RELEASE;
        w.asel = ASEL_ITEM;
      end
      S_RES_RDN: begin
        w.emit = 1'b1;
        w.action = ACT_READ_NEXT;
        w.asel = ASEL_ITEM;
      end
      S_RES_RDP: begin
        w.emit = 1'b1;
        w.action = ACT_READ_PREV;
        w.asel = ASEL_ITEM;
      end
      S_RES_W1: begin
        w.emit = 1'b1;
        w.action = ACT_WRITE;
        w.asel = ASEL_ITEM;
        w.dsel = DSEL_HALT;
        w.last = 1'b1;
        w.cond = C_ALWAYS;
      end
      S_RES_MISS: begin
        w.emit = 1'b1;
        w.status = ST_NOT_FOUND;
        w.action = ACT_RELEASE;
        w.asel = ASEL_ITEM;
        w.last = 1'b1;
        w.cond = C_ALWAYS;
      end
      S_SET: begin
        w.cond = C_HIT;
        w.target = S_SET_DUP;
      end
      S_SET_CHK: begin
        w.cond = C_FULL;
        w.target = S_SET_FULL;
      end
      S_SET_ADD: begin
        w.emit = 1'b1;
        w.action = ACT_WRITE;
        w.asel = ASEL_ITEM;
        w.dsel = DSEL_HALT;
        w.last = 1'b1;
        w.op = OP_APPEND;
        w.cond = C_ALWAYS;
      end
      S_SET_DUP: begin
        w.emit = 1'b1;
        w.status = ST_ALREADY;
        w.last = 1'b1;
        w.cond = C_ALWAYS;
      end
      S_SET_FULL: begin
        w.emit = 1'b1;
        w.status = ST_FULL;
        w.last = 1'b1;
        w.cond = C_ALWAYS;
      end
      S_REM: begin
        w.ld_orig = 1'b1;
        w.cond = C_MISS;
        w.target = S_REM_NF;
      end
      S_REM_RDL: begin
        w.rd_last = 1'b1;
      end
      // keep reading the last entry while the result word waits
      S_REM_DEL: begin
        w.emit = 1'b1;
        w.action = ACT_WRITE;
        w.asel = ASEL_ITEM;
        w.dsel = DSEL_ORIG;
        w.last = 1'b1;
        w.op = OP_REMOVE;
        w.rd_last = 1'b1;
        w.cond = C_ALWAYS;
      end
      S_REM_NF: begin
        w.emit = 1'b1;
        w.status = ST_NOT_FOUND;
        w.last = 1'b1;
        w.cond = C_ALWAYS;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/bpt_table.sv
// breakpoint storage with parallel address match and one registered read port
module bpt_table (
  input  logic                   clk,
  input  bpt_pkg::tbl_wr_t       wr,
  input  logic [15:0]            key,
  input  logic [bpt_pkg::CNT_W-1:0] cnt,
  input  logic [bpt_pkg::IDX_W-1:0] rd_idx,
  output logic                   hit,
  output logic [bpt_pkg::IDX_W-1:0] hit_idx,
  output logic [15:0]            rd_addr,
  output logic [7:0]             rd_orig
);
  import bpt_pkg::*;

  logic [15:0] addr_mem [TABLE_ENTRIES];
  logic [7:0]  orig_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match;
  logic [15:0] rd_addr_r;
  logic [7:0]  rd_orig_r;

  // entry write
  always_ff @(posedge clk) begin
    if (wr.we) begin
      addr_mem[wr.idx] <= wr.addr;
      orig_mem[wr.idx] <= wr.orig;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_addr_r <= addr_mem[rd_idx];
    rd_orig_r <= orig_mem[rd_idx];
  end

  // compare every held entry, at most one matches
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < cnt) && (addr_mem[i] == key);
      if (match[i]) hit_idx = hit_idx | IDX_W'(i);
    end
    hit = |match;
  end

  assign rd_addr = rd_addr_r;
  assign rd_orig = rd_orig_r;

endmodule

FILE: sv/breakpoint_patch_table.sv
// Breakpoint patch table: holds up to TABLE_ENTRIES software breakpoints (address
// and patched-out byte) and turns set, remove and resume commands into result
// words (memory writes of the halt opcode or the original byte, halt release and
// dummy reads). A small control store steps through one control word per clock
// while no result word is held off by out_stall. The input is stalled whenever
// the sequencer is not idle; results are delivered from an output register, and
// last marks the final word of each command that yields result words.
`include "breakpoint_patch_table_assert.svh"

module breakpoint_patch_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_memory_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_action,
  output logic [15:0] out_mem_address,
  output logic [7:0]  out_mem_data,
  output logic [3:0]  out_entry_count,
  output logic        out_last
);
  import bpt_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        cmd_r;
  logic [15:0]       item_addr_r;
  logic [7:0]        item_byte_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [7:0]        orig_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [2:0]        out_action_r;
  logic [15:0]       out_mem_address_r;
  logic [7:0]        out_mem_data_r;
  logic [3:0]        out_entry_count_r;
  logic              out_last_r;

  ucode_t            uw;
  logic              in_acc;
  logic              can_emit;
  logic              go;
  logic              cond_true;
  logic              full;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              tbl_hit;
  logic [IDX_W-1:0]  tbl_hit_idx;
  logic [15:0]       rd_addr;
  logic [7:0]        rd_orig;
  tbl_wr_t           wr;
  logic [CNT_W+3:0]  cnt_ext;
  logic [15:0]       res_addr;
  logic [7:0]        res_data;

  // breakpoint storage
  bpt_table u_table (
    .clk     (clk),
    .wr      (wr),
    .key     (item_addr_r),
    .cnt     (cnt_r),
    .rd_idx  (rd_idx),
    .hit     (tbl_hit),
    .hit_idx (tbl_hit_idx),
    .rd_addr (rd_addr),
    .rd_orig (rd_orig)
  );

  // control word and handshakes
  assign uw       = bpt_ucode(pc_r);
  assign in_stall = (pc_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign can_emit = !out_valid_r || !out_stall;
  assign go       = !uw.emit || can_emit;
  assign full     = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign rd_idx   = uw.rd_last ? last_idx : hit_idx_r;

  // jump condition
  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:  cond_true = 1'b1;
      C_NEVER:   cond_true = 1'b0;
      C_IS_SET:  cond_true = (cmd_r == CMD_SET);
      C_IS_REM:  cond_true = (cmd_r == CMD_REMOVE);
      C_NOT_RES: cond_true = (cmd_r != CMD_RESUME);
      C_MISS:    cond_true = !hit_r;
      C_HIT:     cond_true = hit_r;
      C_FULL:    cond_true = full;
      default:   cond_true = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    priority if (pc_r == S_IDLE) begin
      pc_nxt = in_acc ? S_LOOK : S_IDLE;
    end else if (!go) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  // table update and held count
  always_comb begin
    wr      = '{we: 1'b0, idx: hit_idx_r, addr: rd_addr, orig: rd_orig};
    cnt_nxt = cnt_r;
    if (go) begin
      unique case (uw.op)
        OP_APPEND: begin
          wr = '{we: 1'b1, idx: IDX_W'(cnt_r), addr: item_addr_r, orig: item_byte_r};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        OP_REMOVE: begin
          wr.we = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  // result word fields
  assign res_addr = (uw.asel == ASEL_ITEM) ? item_addr_r : 16'h0000;
  assign cnt_ext  = {4'b0000, cnt_nxt};
  always_comb begin
    unique case (uw.dsel)
      DSEL_ORIG: res_data = orig_r;
      DSEL_HALT: res_data = HALT_OPCODE;
      default:   res_data = 8'h00;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
      if (go && uw.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and lookup registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r       <= in_command;
      item_addr_r <= in_address;
      item_byte_r <= in_memory_byte;
    end
    if (uw.ld_hit) begin
      hit_r     <= tbl_hit;
      hit_idx_r <= tbl_hit_idx;
    end
    if (uw.ld_orig) begin
      orig_r <= rd_orig;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (go && uw.emit) begin
      out_status_r      <= uw.status;
      out_action_r      <= uw.action;
      out_mem_address_r <= res_addr;
      out_mem_data_r    <= res_data;
      out_entry_count_r <= cnt_ext[3:0];
      out_last_r        <= uw.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_action      = out_action_r;
  assign out_mem_address = out_mem_address_r;
  assign out_mem_data    = out_mem_data_r;
  assign out_entry_count = out_entry_count_r;
  assign out_last        = out_last_r;

  // checks
  `BPT_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(TABLE_ENTRIES), "held count above table size")
  `BPT_ASSERT(a_accept_look, in_acc |=> pc_r == S_LOOK, "accepted word did not start lookup")
  `BPT_ASSERT(a_none_zero, out_valid_r && out_action_r == ACT_NONE |-> out_mem_address_r == 16'h0000 && out_mem_data_r == 8'h00, "idle action carries payload")
  `BPT_ASSERT(a_cnt_on_emit, !$stable(cnt_r) |-> $past(go && uw.emit), "held count changed without a result")

endmodule

FILE: verif/breakpoint_patch_table_checker.sv
// result checker for the breakpoint patch table: predicts words per command and compares
`timescale 1ns / 100ps

module breakpoint_patch_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_memory_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [2:0]  out_action,
  input  logic [15:0] out_mem_address,
  input  logic [7:0]  out_mem_data,
  input  logic [3:0]  out_entry_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  import bpt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  action;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [3:0]  entry_count;
    logic        last;
  } result_word_t;

  // predicted words not yet seen on the output, oldest first
  result_word_t expected_words[$];

  // shadow breakpoint table
  logic [15:0] bp_address [TABLE_ENTRIES];
  logic [7:0]  bp_original [TABLE_ENTRIES];
  int          held = 0;
  int          mismatches = 0;

  // index of a held breakpoint, -1 if absent
  function automatic int find_slot(logic [15:0] addr);
    int i;
    for (i = 0; i < held; i++) begin
      if (bp_address[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic void queue_word(logic [1:0] status, logic [2:0] action,
                                     logic [15:0] addr, logic [7:0] data, logic fin);
    result_word_t w;
    w.status      = status;
    w.action      = action;
    w.mem_address = addr;
    w.mem_data    = data;
    w.entry_count = 4'(held);
    w.last        = fin;
    expected_words.push_back(w);
  endfunction

  // update the shadow table and queue the words one command causes
  function automatic void apply_command(logic [1:0] cmd, logic [15:0] addr,
                                        logic [7:0] mem_byte);
    int slot;
    logic [7:0] orig;
    slot = find_slot(addr);
    case (cmd)
      CMD_SET: begin
        if (slot >= 0) begin
          queue_word(ST_ALREADY, ACT_NONE, 16'h0, 8'h0, 1'b1);
        end else if (held >= TABLE_ENTRIES) begin
          queue_word(ST_FULL, ACT_NONE, 16'h0, 8'h0, 1'b1);
        end else begin
          bp_address[held] = addr;
          bp_original[held] = mem_byte;
          held++;
          queue_word(ST_DONE, ACT_WRITE, addr, HALT_OPCODE, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (slot < 0) begin
          queue_word(ST_NOT_FOUND, ACT_NONE, 16'h0, 8'h0, 1'b1);
        end else begin
          orig = bp_original[slot];
          held--;
          // last entry fills the freed slot
          if (slot < held) begin
            bp_address[slot] = bp_address[held];
            bp_original[slot] = bp_original[held];
          end
          queue_word(ST_DONE, ACT_WRITE, addr, orig, 1'b1);
        end
      end
      CMD_RESUME: begin
        if (slot < 0) begin
          queue_word(ST_NOT_FOUND, ACT_RELEASE, addr, 8'h0, 1'b1);
        end else begin
          queue_word(ST_DONE, ACT_WRITE, addr, bp_original[slot], 1'b0);
          queue_word(ST_DONE, ACT_RELEASE, addr, 8'h0, 1'b0);
          queue_word(ST_DONE, ACT_READ_NEXT, addr, 8'h0, 1'b0);
          queue_word(ST_DONE, ACT_READ_PREV, addr, 8'h0, 1'b0);
          queue_word(ST_DONE, ACT_WRITE, addr, HALT_OPCODE, 1'b1);
        end
      end
      default: begin
        // unknown command: no words, table untouched
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // watch both channels; the input side is handled first in each cycle
  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      held = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_command, in_address, in_memory_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with nothing expected, expected none actual %0h/%0h/%0h",
                   $time, out_status, out_action, out_mem_address);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("action", 16'(want.action), 16'(out_action));
          check_field("mem_address", want.mem_address, out_mem_address);
          check_field("mem_data", 16'(want.mem_data), 16'(out_mem_data));
          check_field("entry_count", 16'(want.entry_count), 16'(out_entry_count));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= expected_words.size();
  end

endmodule

FILE: verif/breakpoint_patch_table_test.sv
// top of the breakpoint patch table testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module breakpoint_patch_table_test;
  import bpt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 400;
  localparam int ADDR_POOL      = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_SET;
  logic [15:0] in_address = 16'h0;
  logic [7:0]  in_memory_byte = 8'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_action;
  logic [15:0] out_mem_address;
  logic [7:0]  out_mem_data;
  logic [3:0]  out_entry_count;
  logic        out_last;

  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          out_phase = 0;
  bit          out_steady = 1'b0;
  bit          in_steady = 1'b0;
  logic [15:0] addr_pool [ADDR_POOL];

  breakpoint_patch_table u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_address      (in_address),
    .in_memory_byte  (in_memory_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_action      (out_action),
    .out_mem_address (out_mem_address),
    .out_mem_data    (out_mem_data),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  breakpoint_patch_table_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_address      (in_address),
    .in_memory_byte  (in_memory_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_action      (out_action),
    .out_mem_address (out_mem_address),
    .out_mem_data    (out_mem_data),
    .out_entry_count (out_entry_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure: calm stretches, short holds, a few long ones
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_phase++;
      if (out_phase == 200) begin
        out_phase = 0;
        out_steady = ($urandom_range(0, 2) == 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (out_steady) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
        end else if (r < 92) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(8, 30);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one command word and hold it until accepted
  task automatic send_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] mem_byte);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_memory_byte <= mem_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int counted;
    int r;
    int k;
    logic [1:0] cmd;
    logic [15:0] addr;
    counted = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // address pool keeps hits frequent; both extremes included
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (k = 2; k < ADDR_POOL; k++) addr_pool[k] = 16'($urandom);

    // empty table: resume miss, remove miss, unknown command
    send_word(CMD_RESUME, 16'h0000, 8'hFF);
    send_word(CMD_REMOVE, 16'hFFFF, 8'h00);
    send_word(CMD_UNUSED, 16'hFFFF, 8'hFF);
    // address and byte extremes, duplicate set
    send_word(CMD_SET, 16'h0000, 8'h00);
    send_word(CMD_SET, 16'hFFFF, 8'hFF);
    send_word(CMD_SET, 16'hFFFF, 8'h12);
    // resume hits on both entries
    send_word(CMD_RESUME, 16'hFFFF, 8'h00);
    send_word(CMD_RESUME, 16'h0000, 8'hFF);
    // remove first slot, last entry moves down
    send_word(CMD_REMOVE, 16'h0000, 8'h00);
    send_word(CMD_RESUME, 16'h0000, 8'h00);
    // fill the table
    for (k = 1; k <= TABLE_ENTRIES - 1; k++) begin
      send_word(CMD_SET, 16'(16'h1111 * k), 8'(8'h24 * k));
    end
    // full table, then duplicate while full
    send_word(CMD_SET, 16'hA5A5, 8'h5A);
    send_word(CMD_SET, 16'hFFFF, 8'h00);
    send_word(CMD_UNUSED, 16'h5A5A, 8'hA5);
    // removes at the front of a full table, then at the tail and the middle
    send_word(CMD_REMOVE, 16'hFFFF, 8'h00);
    send_word(CMD_REMOVE, 16'(16'h1111 * (TABLE_ENTRIES - 2)), 8'h00);
    send_word(CMD_RESUME, 16'h3333, 8'h00);
    send_word(CMD_REMOVE, 16'h3333, 8'h00);

    // random commands, mostly on pooled addresses
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) in_steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 5) cmd = CMD_UNUSED;
      else if (r < 45) cmd = CMD_SET;
      else if (r < 68) cmd = CMD_REMOVE;
      else cmd = CMD_RESUME;
      if ($urandom_range(0, 99) < 85) addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      else addr = 16'($urandom);
      send_word(cmd, addr, 8'($urandom));
      if (cmd != CMD_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // let every predicted word come out, then watch for strays
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
